[rtl/cpt_pkg.sv]
// Shared types, widths and region codes for the closest-point-on-triangle block.
// No dependencies; cpt_mul, cpt_check and the top level import this package.
package cpt_pkg;

  // Coordinate format: signed fixed point, 32 bits
  localparam int COORD_BITS = 32;
  localparam int DIFF_W     = COORD_BITS + 1;   // vertex/point differences
  localparam int PROD_W     = 2 * DIFF_W;       // one coordinate product
  localparam int DOT_W      = PROD_W + 2;       // sum of three products
  localparam int E_W        = DOT_W + 1;        // difference of two dots
  localparam int DET_W      = 2 * DOT_W + 1;    // barycentric determinant
  localparam int DEN_W      = DET_W + 2;        // sum of three determinants
  localparam int WP_W       = DET_W + DIFF_W;   // weight times edge component
  localparam int NUM_W      = WP_W + 1;         // sum of two such products
  localparam int QUO_BITS   = COORD_BITS + 3;   // quotient bits produced
  localparam int LIMB_W     = 32;               // multiplier limb

  // Region codes
  localparam logic [2:0] REG_VERT_A  = 3'd0;
  localparam logic [2:0] REG_VERT_B  = 3'd1;
  localparam logic [2:0] REG_EDGE_AB = 3'd2;
  localparam logic [2:0] REG_VERT_C  = 3'd3;
  localparam logic [2:0] REG_EDGE_AC = 3'd4;
  localparam logic [2:0] REG_EDGE_BC = 3'd5;
  localparam logic [2:0] REG_INSIDE  = 3'd6;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] vert_a_x;
    logic signed [COORD_BITS-1:0] vert_a_y;
    logic signed [COORD_BITS-1:0] vert_a_z;
    logic signed [COORD_BITS-1:0] vert_b_x;
    logic signed [COORD_BITS-1:0] vert_b_y;
    logic signed [COORD_BITS-1:0] vert_b_z;
    logic signed [COORD_BITS-1:0] vert_c_x;
    logic signed [COORD_BITS-1:0] vert_c_y;
    logic signed [COORD_BITS-1:0] vert_c_z;
  } query_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic signed [COORD_BITS-1:0] near_z;
    logic [2:0]                   region;
    logic                         degenerate;
  } result_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } cvec_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
    logic signed [DIFF_W-1:0] z;
  } dvec_t;

endpackage

[rtl/cpt_delay.sv]
// Fixed-length delay line for payload that rides alongside the arithmetic.
// Depends on nothing; payload only, so no reset.
module cpt_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap [N];

  // shift every cycle
  always_ff @(posedge clk) begin
    tap[0] <= din;
    for (int k = 1; k < N; k++) begin
      tap[k] <= tap[k-1];
    end
  end

  assign dout = tap[N-1];

endmodule

[rtl/cpt_mul.sv]
// Pipelined signed multiplier built from 33x33 limb products and a registered adder tree.
// Depends on cpt_pkg (limb width).
module cpt_mul #(
  parameter int A_W = 68,
  parameter int B_W = 68
) (
  input  logic                    clk,
  input  logic signed [A_W-1:0]   a,
  input  logic signed [B_W-1:0]   b,
  output logic signed [A_W+B_W-1:0] p
);
  import cpt_pkg::*;

  localparam int LA   = (A_W + LIMB_W - 1) / LIMB_W;
  localparam int LB   = (B_W + LIMB_W - 1) / LIMB_W;
  localparam int NP   = LA * LB;
  localparam int LV   = $clog2(NP);
  localparam int NPAD = 1 << LV;
  localparam int EW   = LIMB_W * (LA + LB) + 2;

  logic signed [LA*LIMB_W-1:0] a_ext;
  logic signed [LB*LIMB_W-1:0] b_ext;
  logic signed [EW-1:0]        tree [LV+1][NPAD];

  assign a_ext = (LA*LIMB_W)'(a);
  assign b_ext = (LB*LIMB_W)'(b);

  // partial products: low limbs unsigned, top limb carries the sign
  for (genvar i = 0; i < LA; i++) begin : g_la
    for (genvar j = 0; j < LB; j++) begin : g_lb
      logic signed [LIMB_W:0]     ea;
      logic signed [LIMB_W:0]     eb;
      logic signed [2*LIMB_W+1:0] pp;
      if (i == LA - 1) begin : g_as
        assign ea = {a_ext[LA*LIMB_W-1], a_ext[i*LIMB_W +: LIMB_W]};
      end else begin : g_au
        assign ea = {1'b0, a_ext[i*LIMB_W +: LIMB_W]};
      end
      if (j == LB - 1) begin : g_bs
        assign eb = {b_ext[LB*LIMB_W-1], b_ext[j*LIMB_W +: LIMB_W]};
      end else begin : g_bu
        assign eb = {1'b0, b_ext[j*LIMB_W +: LIMB_W]};
      end
      assign pp = ea * eb;
      always_ff @(posedge clk) begin
        tree[0][i*LB+j] <= EW'(pp) <<< (LIMB_W * (i + j));
      end
    end
  end

  // padding leaves
  for (genvar k = NP; k < NPAD; k++) begin : g_pad
    always_ff @(posedge clk) begin
      tree[0][k] <= '0;
    end
  end

  // registered pairwise adder tree
  for (genvar l = 0; l < LV; l++) begin : g_lvl
    for (genvar k = 0; k < (NPAD >> (l + 1)); k++) begin : g_add
      always_ff @(posedge clk) begin
        tree[l+1][k] <= tree[l][2*k] + tree[l][2*k+1];
      end
    end
  end

  assign p = tree[LV][0][A_W+B_W-1:0];

endmodule

[rtl/cpt_div.sv]
// Pipelined signed divider, one quotient bit per stage, adding the quotient to a base.
// Depends on nothing. Quotient truncates toward zero.
module cpt_div #(
  parameter int N_W = 171,
  parameter int D_W = 139,
  parameter int Q_W = 35,
  parameter int R_W = 32
) (
  input  logic                  clk,
  input  logic signed [N_W-1:0] num,
  input  logic signed [D_W-1:0] den,
  input  logic signed [R_W-1:0] base,
  output logic signed [R_W-1:0] res
);

  localparam int RW = D_W + 1;

  logic [RW-1:0]  rem [Q_W+1];
  logic [Q_W-1:0] lo  [Q_W+1];
  logic [Q_W-1:0] qq  [Q_W+1];
  logic [D_W-1:0] dm  [Q_W+1];
  logic           neg [Q_W+1];
  logic [R_W-1:0] bs  [Q_W+1];
  logic [N_W-1:0] nm;
  logic [D_W-1:0] dmag;
  logic [Q_W-1:0] qs;

  // magnitudes
  assign nm   = num[N_W-1] ? N_W'(-num) : N_W'(num);
  assign dmag = den[D_W-1] ? D_W'(-den) : D_W'(den);

  always_ff @(posedge clk) begin
    rem[0] <= RW'(nm >> Q_W);
    lo[0]  <= nm[Q_W-1:0];
    qq[0]  <= '0;
    dm[0]  <= dmag;
    neg[0] <= num[N_W-1] ^ den[D_W-1];
    bs[0]  <= base;
  end

  // restoring steps
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = {rem[k][RW-2:0], lo[k][Q_W-1]};
    assign ge = sh >= {1'b0, dm[k]};
    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? sh - {1'b0, dm[k]} : sh;
      lo[k+1]  <= lo[k] << 1;
      qq[k+1]  <= {qq[k][Q_W-2:0], ge};
      dm[k+1]  <= dm[k];
      neg[k+1] <= neg[k];
      bs[k+1]  <= bs[k];
    end
  end

  // sign and offset
  assign qs = neg[Q_W] ? -qq[Q_W] : qq[Q_W];

  always_ff @(posedge clk) begin
    res <= $signed(bs[Q_W] + qs[R_W-1:0]);
  end

endmodule

[rtl/closest_point_on_triangle.sv]
// Closest point on a triangle: top level. Uses cpt_pkg, cpt_delay, cpt_mul and cpt_div.
// Fully pipelined; one query may be started in every cycle.
//
// Takes a query point and triangle a, b, c (signed Q16.16) on start and strobes the
// nearest point of the triangle, its region code and a degenerate flag on done.
// busy is always low: one item per cycle, and done cannot be held off, so the
// receiver must take every result as it appears.
// Most of the latency is the divider with its 35 restoring stages, which turns
// weights into edge or interior offsets; the determinant and weight multipliers
// add five stages each. A zero denominator (collinear or coincident vertices)
// returns vertex a, region 0, degenerate set.
module closest_point_on_triangle (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  cpt_pkg::query_t query,
  output logic            done,
  output cpt_pkg::result_t result
);
  import cpt_pkg::*;

  localparam int DL    = (DOT_W + LIMB_W - 1) / LIMB_W;
  localparam int L1    = 1 + $clog2(DL * DL);
  localparam int WL    = (DET_W + LIMB_W - 1) / LIMB_W;
  localparam int UL    = (DIFF_W + LIMB_W - 1) / LIMB_W;
  localparam int L2    = 1 + $clog2(WL * UL);
  localparam int LD    = QUO_BITS + 2;
  localparam int OUT_I = 7 + L1 + L2 + LD;

  localparam int MA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int MB [6] = '{3, 1, 1, 5, 5, 3};

  typedef struct packed {
    cvec_t a;
    cvec_t b;
    cvec_t c;
    dvec_t ab;
    dvec_t ac;
    dvec_t bc;
  } geo_t;

  typedef struct packed {
    cvec_t                   base;
    logic signed [DEN_W-1:0] den;
    logic [2:0]              rg;
    logic                    dg;
  } side_t;

  typedef struct packed {
    logic [2:0] rg;
    logic       dg;
  } tag_t;

  function automatic logic le0(input logic signed [DET_W-1:0] x);
    return x[DET_W-1] || (x == '0);
  endfunction

  logic [OUT_I:0] vld;
  query_t         in_q;

  // stage 1
  dvec_t ab1, ac1, ap1, bp1, cp1, bc1;
  cvec_t a1, b1, c1;
  geo_t  geo1, geo5;

  // stage 2, 3
  dvec_t                    lft [6];
  dvec_t                    rgt [6];
  logic signed [PROD_W-1:0] prod [6][3];
  logic signed [DOT_W-1:0]  dot [6];
  logic [6*DOT_W-1:0]       dot_pk, dot_dl;
  logic signed [DOT_W-1:0]  dd [6];
  logic signed [2*DOT_W-1:0] dp [6];

  // stage 4
  logic signed [DET_W-1:0] va4, vb4, vc4;
  logic signed [DOT_W-1:0] d4r [6];
  logic signed [E_W-1:0]   e1_4, e2_4, dab4, dac4;

  // stage 5
  logic [2:0]              rg5;
  logic signed [DOT_W-1:0] d1_5, d2_5;
  logic signed [E_W-1:0]   e1_5, dab5, dac5;
  logic signed [E_W:0]     ebc5;
  logic signed [DET_W-1:0] vb5, vc5;
  logic signed [DEN_W-1:0] dint5;
  logic [2:0]              rg_next;

  // stage 6
  cvec_t                   base_next, base6;
  dvec_t                   u_next, v_next, u6, v6;
  logic signed [DET_W-1:0] w1_next, w2_next, w1_6, w2_6;
  logic signed [DEN_W-1:0] den_next, den6;
  logic [2:0]              rg6_next, rg6;
  logic                    dg6_next, dg6;

  // stage 7 and divider
  logic signed [WP_W-1:0]       pu [3];
  logic signed [WP_W-1:0]       pv [3];
  logic signed [DIFF_W-1:0]     ucmp [3];
  logic signed [DIFF_W-1:0]     vcmp [3];
  logic signed [COORD_BITS-1:0] bcmp [3];
  logic signed [NUM_W-1:0]      num7 [3];
  logic signed [COORD_BITS-1:0] near [3];
  side_t                        side6, side7;
  tag_t                         tag7, tag_out;

  assign busy = 1'b0;

  // valid bits travel with the items
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[OUT_I-1:0], start & ~busy};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    in_q <= query;
  end

  // stage 1: edge and point differences
  always_ff @(posedge clk) begin
    ab1.x <= DIFF_W'(in_q.vert_b_x) - DIFF_W'(in_q.vert_a_x);
    ab1.y <= DIFF_W'(in_q.vert_b_y) - DIFF_W'(in_q.vert_a_y);
    ab1.z <= DIFF_W'(in_q.vert_b_z) - DIFF_W'(in_q.vert_a_z);
    ac1.x <= DIFF_W'(in_q.vert_c_x) - DIFF_W'(in_q.vert_a_x);
    ac1.y <= DIFF_W'(in_q.vert_c_y) - DIFF_W'(in_q.vert_a_y);
    ac1.z <= DIFF_W'(in_q.vert_c_z) - DIFF_W'(in_q.vert_a_z);
    ap1.x <= DIFF_W'(in_q.point_x) - DIFF_W'(in_q.vert_a_x);
    ap1.y <= DIFF_W'(in_q.point_y) - DIFF_W'(in_q.vert_a_y);
    ap1.z <= DIFF_W'(in_q.point_z) - DIFF_W'(in_q.vert_a_z);
    bp1.x <= DIFF_W'(in_q.point_x) - DIFF_W'(in_q.vert_b_x);
    bp1.y <= DIFF_W'(in_q.point_y) - DIFF_W'(in_q.vert_b_y);
    bp1.z <= DIFF_W'(in_q.point_z) - DIFF_W'(in_q.vert_b_z);
    cp1.x <= DIFF_W'(in_q.point_x) - DIFF_W'(in_q.vert_c_x);
    cp1.y <= DIFF_W'(in_q.point_y) - DIFF_W'(in_q.vert_c_y);
    cp1.z <= DIFF_W'(in_q.point_z) - DIFF_W'(in_q.vert_c_z);
    bc1.x <= DIFF_W'(in_q.vert_c_x) - DIFF_W'(in_q.vert_b_x);
    bc1.y <= DIFF_W'(in_q.vert_c_y) - DIFF_W'(in_q.vert_b_y);
    bc1.z <= DIFF_W'(in_q.vert_c_z) - DIFF_W'(in_q.vert_b_z);
    a1    <= '{in_q.vert_a_x, in_q.vert_a_y, in_q.vert_a_z};
    b1    <= '{in_q.vert_b_x, in_q.vert_b_y, in_q.vert_b_z};
    c1    <= '{in_q.vert_c_x, in_q.vert_c_y, in_q.vert_c_z};
  end

  assign geo1 = '{a: a1, b: b1, c: c1, ab: ab1, ac: ac1, bc: bc1};

  // stage 2: coordinate products for d1..d6
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      lft[k] = (k % 2 == 0) ? ab1 : ac1;
      rgt[k] = (k < 2) ? ap1 : ((k < 4) ? bp1 : cp1);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      prod[k][0] <= lft[k].x * rgt[k].x;
      prod[k][1] <= lft[k].y * rgt[k].y;
      prod[k][2] <= lft[k].z * rgt[k].z;
    end
  end

  // stage 3: dot products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      dot[k] <= DOT_W'(prod[k][0]) + DOT_W'(prod[k][1]) + DOT_W'(prod[k][2]);
    end
  end

  // determinant products d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  for (genvar k = 0; k < 6; k++) begin : g_det
    cpt_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_mul (
      .clk (clk),
      .a   (dot[MA[k]]),
      .b   (dot[MB[k]]),
      .p   (dp[k])
    );
    assign dot_pk[k*DOT_W +: DOT_W] = dot[k];
    assign dd[k] = $signed(dot_dl[k*DOT_W +: DOT_W]);
  end

  cpt_delay #(.W(6*DOT_W), .N(L1)) u_dot_dl (
    .clk  (clk),
    .din  (dot_pk),
    .dout (dot_dl)
  );

  // stage 4: determinants and dot differences
  always_ff @(posedge clk) begin
    vc4  <= DET_W'(dp[0]) - DET_W'(dp[1]);
    vb4  <= DET_W'(dp[2]) - DET_W'(dp[3]);
    va4  <= DET_W'(dp[4]) - DET_W'(dp[5]);
    e1_4 <= E_W'(dd[3]) - E_W'(dd[2]);
    e2_4 <= E_W'(dd[4]) - E_W'(dd[5]);
    dab4 <= E_W'(dd[0]) - E_W'(dd[2]);
    dac4 <= E_W'(dd[1]) - E_W'(dd[5]);
    for (int k = 0; k < 6; k++) begin
      d4r[k] <= dd[k];
    end
  end

  // stage 5: region tests in priority order
  always_comb begin
    if (le0(DET_W'(d4r[0])) && le0(DET_W'(d4r[1]))) begin
      rg_next = REG_VERT_A;
    end else if (!d4r[2][DOT_W-1] && le0(DET_W'(e1_4))) begin
      rg_next = REG_VERT_B;
    end else if (le0(vc4) && !d4r[0][DOT_W-1] && le0(DET_W'(d4r[2]))) begin
      rg_next = REG_EDGE_AB;
    end else if (!d4r[5][DOT_W-1] && le0(DET_W'(e2_4))) begin
      rg_next = REG_VERT_C;
    end else if (le0(vb4) && !d4r[1][DOT_W-1] && le0(DET_W'(d4r[5]))) begin
      rg_next = REG_EDGE_AC;
    end else if (le0(va4) && !e1_4[E_W-1] && !e2_4[E_W-1]) begin
      rg_next = REG_EDGE_BC;
    end else begin
      rg_next = REG_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    rg5   <= rg_next;
    d1_5  <= d4r[0];
    d2_5  <= d4r[1];
    e1_5  <= e1_4;
    dab5  <= dab4;
    dac5  <= dac4;
    ebc5  <= (E_W+1)'(e1_4) + (E_W+1)'(e2_4);
    vb5   <= vb4;
    vc5   <= vc4;
    dint5 <= DEN_W'(va4) + DEN_W'(vb4) + DEN_W'(vc4);
  end

  cpt_delay #(.W($bits(geo_t)), .N(L1 + 4)) u_geo_dl (
    .clk  (clk),
    .din  (geo1),
    .dout (geo5)
  );

  // stage 6: pick base, weights, edge vectors and denominator
  always_comb begin
    base_next = geo5.a;
    w1_next   = '0;
    w2_next   = '0;
    u_next    = geo5.ab;
    v_next    = geo5.ac;
    den_next  = DEN_W'(1);
    rg6_next  = rg5;
    dg6_next  = 1'b0;
    case (rg5)
      REG_VERT_A: begin
        base_next = geo5.a;
      end
      REG_VERT_B: begin
        base_next = geo5.b;
      end
      REG_VERT_C: begin
        base_next = geo5.c;
      end
      REG_EDGE_AB: begin
        w1_next  = DET_W'(d1_5);
        den_next = DEN_W'(dab5);
      end
      REG_EDGE_AC: begin
        w1_next  = DET_W'(d2_5);
        u_next   = geo5.ac;
        den_next = DEN_W'(dac5);
      end
      REG_EDGE_BC: begin
        base_next = geo5.b;
        w1_next   = DET_W'(e1_5);
        u_next    = geo5.bc;
        den_next  = DEN_W'(ebc5);
      end
      default: begin
        w1_next  = vb5;
        w2_next  = vc5;
        den_next = dint5;
      end
    endcase
    // degenerate triangle: fall back to vertex a
    if (den_next == '0) begin
      base_next = geo5.a;
      w1_next   = '0;
      w2_next   = '0;
      den_next  = DEN_W'(1);
      rg6_next  = REG_VERT_A;
      dg6_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    base6 <= base_next;
    w1_6  <= w1_next;
    w2_6  <= w2_next;
    u6    <= u_next;
    v6    <= v_next;
    den6  <= den_next;
    rg6   <= rg6_next;
    dg6   <= dg6_next;
  end

  assign ucmp[0] = u6.x;
  assign ucmp[1] = u6.y;
  assign ucmp[2] = u6.z;
  assign vcmp[0] = v6.x;
  assign vcmp[1] = v6.y;
  assign vcmp[2] = v6.z;
  assign bcmp[0] = side7.base.x;
  assign bcmp[1] = side7.base.y;
  assign bcmp[2] = side7.base.z;

  // weight products, numerator sum and division per axis
  for (genvar i = 0; i < 3; i++) begin : g_axis
    cpt_mul #(.A_W(DET_W), .B_W(DIFF_W)) u_mul_u (
      .clk (clk),
      .a   (w1_6),
      .b   (ucmp[i]),
      .p   (pu[i])
    );
    cpt_mul #(.A_W(DET_W), .B_W(DIFF_W)) u_mul_v (
      .clk (clk),
      .a   (w2_6),
      .b   (vcmp[i]),
      .p   (pv[i])
    );
    always_ff @(posedge clk) begin
      num7[i] <= NUM_W'(pu[i]) + NUM_W'(pv[i]);
    end
    cpt_div #(.N_W(NUM_W), .D_W(DEN_W), .Q_W(QUO_BITS), .R_W(COORD_BITS)) u_div (
      .clk  (clk),
      .num  (num7[i]),
      .den  (side7.den),
      .base (bcmp[i]),
      .res  (near[i])
    );
  end

  assign side6 = '{base: base6, den: den6, rg: rg6, dg: dg6};

  cpt_delay #(.W($bits(side_t)), .N(L2 + 1)) u_side_dl (
    .clk  (clk),
    .din  (side6),
    .dout (side7)
  );

  assign tag7 = '{rg: side7.rg, dg: side7.dg};

  cpt_delay #(.W($bits(tag_t)), .N(LD)) u_tag_dl (
    .clk  (clk),
    .din  (tag7),
    .dout (tag_out)
  );

  // result
  assign done              = vld[OUT_I];
  assign result.near_x     = near[0];
  assign result.near_y     = near[1];
  assign result.near_z     = near[2];
  assign result.region     = tag_out.rg;
  assign result.degenerate = tag_out.dg;

endmodule

[rtl/cpt_check.sv]
// Port-level checks for closest_point_on_triangle, with the bind that attaches them.
// Depends on cpt_pkg for the result type.
module cpt_check (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input cpt_pkg::result_t result
);
  import cpt_pkg::*;

  // pipeline never refuses an item
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // nothing in flight right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");

  // degenerate fallback always reports vertex a
  a_deg_region: assert property (@(posedge clk) disable iff (rst)
    done && result.degenerate |-> result.region == REG_VERT_A)
    else $error("degenerate without region a");

  // region code stays in its range
  a_region_code: assert property (@(posedge clk) disable iff (rst)
    done |-> result.region != 3'd7)
    else $error("bad region code");

endmodule

bind closest_point_on_triangle cpt_check u_cpt_check (.*);
